// File: hw/rtl/ttl_abt_pkg.sv
// Package for the TTL address block table: word formats, command and status
// codes, memory entry formats and default sizes. No dependencies.
package ttl_abt_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int HEAP_ENTRIES_DEF  = 2048;
    localparam int MAX_POPS          = 16384;
    localparam int LIMIT_W           = 15;
    localparam int FILL_W            = 12;

    localparam logic [1:0] CMD_BLOCK   = 2'd0;
    localparam logic [1:0] CMD_QUERY   = 2'd1;
    localparam logic [1:0] CMD_CLEANUP = 2'd2;

    localparam logic [1:0] ST_ADDED     = 2'd0;
    localparam logic [1:0] ST_REFRESHED = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
        logic [19:0] ttl;
        logic [31:0] now;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic               blocked;
        logic [LIMIT_W-1:0] released;
        logic [FILL_W-1:0]  heap_fill;
    } t_out_word;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [31:0] expiry;
    } t_tbl_ent;

    // Expiry in the upper half so a plain compare orders by expiry, then address.
    typedef struct packed {
        logic [31:0] expiry;
        logic [31:0] addr;
    } t_heap_ent;

    typedef enum logic [15:0] {
        S_INIT     = 16'h0001,
        S_IDLE     = 16'h0002,
        S_SCAN     = 16'h0004,
        S_POST     = 16'h0008,
        S_PUSH_RD  = 16'h0010,
        S_PUSH_CMP = 16'h0020,
        S_PUSH_WR  = 16'h0040,
        S_CL_CHK   = 16'h0080,
        S_CL_PEEK  = 16'h0100,
        S_POP_RD   = 16'h0200,
        S_POP_LAST = 16'h0400,
        S_SD_RDL   = 16'h0800,
        S_SD_GETL  = 16'h1000,
        S_SD_GETR  = 16'h2000,
        S_SD_DEC   = 16'h4000,
        S_OUT      = 16'h8000
    } t_state;

endpackage

// File: hw/rtl/ttl_address_block_table_unit.sv
// Top level of the TTL address block table: address table memory, expiry
// min-heap memory, command sequencer and APB register. Uses ttl_abt_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command word: block,
//   query or cleanup tick. Output channel (o_out_valid / i_out_ready) returns
//   exactly one result word per command, in order.
//   The block works on one command at a time. Table lookups scan the address
//   table memory one entry per cycle; a block also sifts its new entry up
//   the heap (up to log2(HEAP_ENTRIES) levels). A cleanup tick does, per
//   popped entry, a heap sift-down plus one table scan; each memory gives
//   one read per cycle.
//   The result waits in an output register; a new command is taken as soon
//   as the previous result is loaded there, even while the receiver stalls.
//   After reset the table memory is swept clear with o_in_ready low; the
//   heap starts empty and cleanup_limit is 16384.
//   cleanup_limit sits at byte address 0 of the APB port; write it only
//   while the block is idle.
module ttl_address_block_table_unit
    import ttl_abt_pkg::*;
#(
    parameter int TABLE_ENTRIES = ttl_abt_pkg::TABLE_ENTRIES_DEF,
    parameter int HEAP_ENTRIES  = ttl_abt_pkg::HEAP_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ttl_abt_pkg::t_in_word i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ttl_abt_pkg::t_out_word o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int HW = $clog2(HEAP_ENTRIES);
    localparam int CW = $clog2(HEAP_ENTRIES + 1);
    localparam int XW = HW + 2;

    // Memories
    t_tbl_ent  tbl_mem [TABLE_ENTRIES];
    t_heap_ent heap_mem[HEAP_ENTRIES];
    t_tbl_ent  tbl_rd;
    t_heap_ent heap_rd;
    logic          tbl_we;
    logic [TW-1:0] tbl_wa, tbl_ra;
    t_tbl_ent      tbl_wd;
    logic          heap_we;
    logic [HW-1:0] heap_wa, heap_ra;
    t_heap_ent     heap_wd;

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        tbl_rd <= tbl_mem[tbl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            heap_mem[heap_wa] <= heap_wd;
        end
        heap_rd <= heap_mem[heap_ra];
    end

    // Registers
    t_state             r_state, n_state;
    logic [1:0]         r_cmd, n_cmd;
    logic [31:0]        r_tgt, n_tgt;
    logic [31:0]        r_now, n_now;
    logic [31:0]        r_exp, n_exp;
    logic [TW:0]        r_k, n_k;
    logic               r_pend, n_pend;
    logic [TW-1:0]      r_pidx, n_pidx;
    logic               r_hit, n_hit;
    logic [TW-1:0]      r_hit_idx, n_hit_idx;
    logic [31:0]        r_hit_exp, n_hit_exp;
    logic               r_free, n_free;
    logic [TW-1:0]      r_free_idx, n_free_idx;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [HW-1:0]      r_i, n_i;
    logic [HW-1:0]      r_m, n_m;
    t_heap_ent          r_last, n_last;
    t_heap_ent          r_best, n_best;
    logic               r_moved, n_moved;
    logic [LIMIT_W-1:0] r_n, n_n;
    logic [31:0]        r_pe, n_pe;
    logic [1:0]         r_status, n_status;
    logic               r_blocked, n_blocked;
    logic [LIMIT_W-1:0] r_rel, n_rel;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_ovld, n_ovld;
    t_out_word          r_odata, n_odata;

    // Helpers
    logic [32:0]        exp_sum;
    logic [31:0]        exp_sat;
    logic [LIMIT_W-1:0] lim;
    logic [XW-1:0]      idx_l, idx_r, cnt_x;
    logic [HW-1:0]      parent;
    logic [CW-1:0]      cnt_dec;
    t_heap_ent          new_ent;
    logic [31:0]        fill_ext;
    logic               cfg_wr;

    assign exp_sum = {1'b0, i_in_data.now} + 33'(i_in_data.ttl);
    assign exp_sat = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
    assign lim     = (r_limit > LIMIT_W'(MAX_POPS)) ? LIMIT_W'(MAX_POPS) : r_limit;
    assign idx_l   = {1'b0, r_i, 1'b1};
    assign idx_r   = idx_l + XW'(1);
    assign cnt_x   = XW'(r_cnt);
    assign parent  = (r_i - HW'(1)) >> 1;
    assign cnt_dec = r_cnt - CW'(1);
    assign new_ent = '{expiry: r_exp, addr: r_tgt};
    assign fill_ext = 32'(n_cnt);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32 - LIMIT_W){1'b0}}, r_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(MAX_POPS);
        end else if (cfg_wr) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_tgt      = r_tgt;
        n_now      = r_now;
        n_exp      = r_exp;
        n_k        = r_k;
        n_pend     = 1'b0;
        n_pidx     = r_pidx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_exp  = r_hit_exp;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_cnt      = r_cnt;
        n_i        = r_i;
        n_m        = r_m;
        n_last     = r_last;
        n_best     = r_best;
        n_moved    = r_moved;
        n_n        = r_n;
        n_pe       = r_pe;
        n_status   = r_status;
        n_blocked  = r_blocked;
        n_rel      = r_rel;
        n_ovld     = r_ovld && !i_out_ready;
        n_odata    = r_odata;

        tbl_we  = 1'b0;
        tbl_wa  = r_k[TW-1:0];
        tbl_wd  = '0;
        tbl_ra  = r_k[TW-1:0];
        heap_we = 1'b0;
        heap_wa = r_i;
        heap_wd = new_ent;
        heap_ra = '0;

        case (r_state)
            S_INIT: begin
                // sweep the table clear, one entry a cycle
                tbl_we = 1'b1;
                n_k    = r_k + (TW + 1)'(1);
                if (r_k == (TW + 1)'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd      = i_in_data.command;
                    n_tgt      = i_in_data.address;
                    n_now      = i_in_data.now;
                    n_exp      = exp_sat;
                    n_status   = ST_ADDED;
                    n_blocked  = 1'b0;
                    n_rel      = '0;
                    n_n        = '0;
                    n_k        = '0;
                    n_hit      = 1'b0;
                    n_free     = 1'b0;
                    case (i_in_data.command)
                        CMD_BLOCK: begin
                            if (r_cnt == CW'(HEAP_ENTRIES)) begin
                                n_status = ST_FULL;
                                n_state  = S_OUT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_QUERY:   n_state = S_SCAN;
                        CMD_CLEANUP: n_state = S_CL_CHK;
                        default:     n_state = S_OUT;
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read a cycle, judge the entry read last cycle
                if (r_k < (TW + 1)'(TABLE_ENTRIES)) begin
                    n_pend = 1'b1;
                    n_pidx = r_k[TW-1:0];
                    n_k    = r_k + (TW + 1)'(1);
                end
                if (r_pend) begin
                    if (tbl_rd.valid && tbl_rd.addr == r_tgt) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_pidx;
                        n_hit_exp = tbl_rd.expiry;
                        n_state   = S_POST;
                    end else begin
                        if (!tbl_rd.valid && !r_free) begin
                            n_free     = 1'b1;
                            n_free_idx = r_pidx;
                        end
                        if (r_pidx == TW'(TABLE_ENTRIES - 1)) begin
                            n_state = S_POST;
                        end
                    end
                end
            end
            S_POST: begin
                case (r_cmd)
                    CMD_BLOCK: begin
                        tbl_wd = '{valid: 1'b1, addr: r_tgt, expiry: r_exp};
                        if (r_hit || r_free) begin
                            tbl_we   = 1'b1;
                            tbl_wa   = r_hit ? r_hit_idx : r_free_idx;
                            n_status = r_hit ? ST_REFRESHED : ST_ADDED;
                            n_i      = r_cnt[HW-1:0];
                            n_cnt    = r_cnt + CW'(1);
                            n_state  = S_PUSH_RD;
                        end else begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end
                    end
                    CMD_QUERY: begin
                        n_blocked = r_hit && (r_now < r_hit_exp);
                        n_state   = S_OUT;
                    end
                    default: begin
                        // drop the table entry only if the popped expiry still owns it
                        tbl_wa = r_hit_idx;
                        tbl_wd = '{valid: 1'b0, addr: r_tgt, expiry: r_hit_exp};
                        if (r_hit && r_hit_exp == r_pe) begin
                            tbl_we = 1'b1;
                            n_rel  = r_rel + LIMIT_W'(1);
                        end
                        n_state = S_CL_CHK;
                    end
                endcase
            end
            S_PUSH_RD: begin
                if (r_i == '0) begin
                    n_state = S_PUSH_WR;
                end else begin
                    heap_ra = parent;
                    n_m     = parent;
                    n_state = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP: begin
                if (new_ent < heap_rd) begin
                    // move the parent down into the hole
                    heap_we = 1'b1;
                    heap_wd = heap_rd;
                    n_i     = r_m;
                    n_state = S_PUSH_RD;
                end else begin
                    n_state = S_PUSH_WR;
                end
            end
            S_PUSH_WR: begin
                heap_we = 1'b1;
                n_state = S_OUT;
            end
            S_CL_CHK: begin
                if (r_n < lim && r_cnt != '0) begin
                    heap_ra = '0;
                    n_state = S_CL_PEEK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_CL_PEEK: begin
                if (heap_rd.expiry <= r_now) begin
                    n_pe   = heap_rd.expiry;
                    n_tgt  = heap_rd.addr;
                    n_n    = r_n + LIMIT_W'(1);
                    n_cnt  = cnt_dec;
                    n_k    = '0;
                    n_hit  = 1'b0;
                    n_free = 1'b0;
                    n_state = (cnt_dec == '0) ? S_SCAN : S_POP_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_POP_RD: begin
                heap_ra = r_cnt[HW-1:0];
                n_state = S_POP_LAST;
            end
            S_POP_LAST: begin
                n_last  = heap_rd;
                n_i     = '0;
                n_state = S_SD_RDL;
            end
            S_SD_RDL: begin
                if (idx_l < cnt_x) begin
                    heap_ra = idx_l[HW-1:0];
                    n_state = S_SD_GETL;
                end else begin
                    heap_we = 1'b1;
                    heap_wd = r_last;
                    n_state = S_SCAN;
                end
            end
            S_SD_GETL: begin
                if (heap_rd < r_last) begin
                    n_best  = heap_rd;
                    n_m     = idx_l[HW-1:0];
                    n_moved = 1'b1;
                end else begin
                    n_best  = r_last;
                    n_moved = 1'b0;
                end
                if (idx_r < cnt_x) begin
                    heap_ra = idx_r[HW-1:0];
                    n_state = S_SD_GETR;
                end else begin
                    n_state = S_SD_DEC;
                end
            end
            S_SD_GETR: begin
                if (heap_rd < r_best) begin
                    n_best  = heap_rd;
                    n_m     = idx_r[HW-1:0];
                    n_moved = 1'b1;
                end
                n_state = S_SD_DEC;
            end
            S_SD_DEC: begin
                heap_we = 1'b1;
                if (r_moved) begin
                    heap_wd = r_best;
                    n_i     = r_m;
                    n_state = S_SD_RDL;
                end else begin
                    heap_wd = r_last;
                    n_state = S_SCAN;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ovld || i_out_ready) begin
                    n_ovld  = 1'b1;
                    n_odata = '{status:    (r_cmd == CMD_BLOCK) ? r_status : ST_ADDED,
                                blocked:   r_blocked,
                                released:  r_rel,
                                heap_fill: fill_ext[FILL_W-1:0]};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_k     <= '0;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_tgt      <= n_tgt;
        r_now      <= n_now;
        r_exp      <= n_exp;
        r_pidx     <= n_pidx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_exp  <= n_hit_exp;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_i        <= n_i;
        r_m        <= n_m;
        r_last     <= n_last;
        r_best     <= n_best;
        r_moved    <= n_moved;
        r_n        <= n_n;
        r_pe       <= n_pe;
        r_status   <= n_status;
        r_blocked  <= n_blocked;
        r_rel      <= n_rel;
        r_odata    <= n_odata;
    end

endmodule

// File: verif/tb_ttl_address_block_table_unit.sv
`timescale 1ns / 100ps
// Testbench for ttl_address_block_table_unit: directed table plus random
// block/query/cleanup words checked against an in-bench table and heap model.
// Depends on ttl_abt_pkg and the unit's RTL.
module tb_ttl_address_block_table_unit;
    import ttl_abt_pkg::*;

    localparam int          N_TBL   = TABLE_ENTRIES_DEF;
    localparam int          N_HEAP  = HEAP_ENTRIES_DEF;
    localparam logic [1:0]  CMD_NOP = 2'd3;
    localparam logic [2:0]  ADDR_LIMIT = 3'd0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ttl_address_block_table_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state: address table, expiry heap keyed {expiry, address}, limit.
    logic [31:0] mdl_tbl_addr [N_TBL];
    logic [31:0] mdl_tbl_exp  [N_TBL];
    bit          mdl_tbl_vld  [N_TBL];
    logic [63:0] mdl_heap     [N_HEAP];
    int          mdl_heap_cnt = 0;
    int          mdl_limit = MAX_POPS;

    t_out_word   expected_words[$];
    int          errors = 0;
    logic [31:0] addr_pool [16];
    logic [31:0] now_t = '0;

    function automatic int find_slot(logic [31:0] a);
        for (int k = 0; k < N_TBL; k++)
            if (mdl_tbl_vld[k] && mdl_tbl_addr[k] == a) return k;
        return -1;
    endfunction

    function automatic int table_fill();
        int n;
        n = 0;
        for (int k = 0; k < N_TBL; k++) n += mdl_tbl_vld[k];
        return n;
    endfunction

    // Compute the result of one command and advance the model state.
    function automatic t_out_word predict_word(t_in_word w);
        t_out_word   r;
        logic [32:0] sum;
        logic [31:0] expiry, e, a;
        logic [63:0] tmp;
        int          slot, k, i, p, l, m, lim, n;
        r = '0;
        case (w.command)
            CMD_BLOCK: begin
                sum = {1'b0, w.now} + w.ttl;
                expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                slot = find_slot(w.address);
                k = 0;
                if (slot < 0)
                    while (k < N_TBL && mdl_tbl_vld[k]) k++;
                if (mdl_heap_cnt >= N_HEAP || (slot < 0 && k == N_TBL)) begin
                    r.status = ST_FULL;
                end else begin
                    if (slot >= 0) begin
                        mdl_tbl_exp[slot] = expiry;
                        r.status = ST_REFRESHED;
                    end else begin
                        mdl_tbl_vld[k] = 1'b1;
                        mdl_tbl_addr[k] = w.address;
                        mdl_tbl_exp[k] = expiry;
                        r.status = ST_ADDED;
                    end
                    // sift up
                    i = mdl_heap_cnt;
                    mdl_heap[i] = {expiry, w.address};
                    mdl_heap_cnt++;
                    while (i > 0) begin
                        p = (i - 1) / 2;
                        if (mdl_heap[i] >= mdl_heap[p]) break;
                        tmp = mdl_heap[i]; mdl_heap[i] = mdl_heap[p]; mdl_heap[p] = tmp;
                        i = p;
                    end
                end
            end
            CMD_QUERY: begin
                slot = find_slot(w.address);
                r.blocked = (slot >= 0) && (w.now < mdl_tbl_exp[slot]);
            end
            CMD_CLEANUP: begin
                lim = (mdl_limit > MAX_POPS) ? MAX_POPS : mdl_limit;
                n = 0;
                while (n < lim && mdl_heap_cnt > 0 && mdl_heap[0][63:32] <= w.now) begin
                    e = mdl_heap[0][63:32];
                    a = mdl_heap[0][31:0];
                    mdl_heap_cnt--;
                    if (mdl_heap_cnt > 0) begin
                        mdl_heap[0] = mdl_heap[mdl_heap_cnt];
                        i = 0;
                        forever begin
                            l = 2 * i + 1;
                            m = i;
                            if (l < mdl_heap_cnt && mdl_heap[l] < mdl_heap[m]) m = l;
                            if (l + 1 < mdl_heap_cnt && mdl_heap[l + 1] < mdl_heap[m]) m = l + 1;
                            if (m == i) break;
                            tmp = mdl_heap[i]; mdl_heap[i] = mdl_heap[m]; mdl_heap[m] = tmp;
                            i = m;
                        end
                    end
                    slot = find_slot(a);
                    // stale pairs are dropped without touching the table
                    if (slot >= 0 && mdl_tbl_exp[slot] == e) begin
                        mdl_tbl_vld[slot] = 1'b0;
                        r.released++;
                    end
                    n++;
                end
            end
            default: ;
        endcase
        r.heap_fill = mdl_heap_cnt[FILL_W-1:0];
        return r;
    endfunction

    // Hold valid and payload until the word is taken; lower valid only for a random gap before a word.
    task automatic send_word(t_in_word w);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        expected_words.push_back(predict_word(w));
    endtask

    // Drop valid and wait for every outstanding result, then settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // APB write of cleanup_limit followed by a read back; only while idle.
    task automatic write_limit(logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_LIMIT; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        mdl_limit = v & 32'h7FFF;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata != mdl_limit) begin
            $display("%0t: cleanup_limit read back expected %0d actual %0d",
                     $time, mdl_limit, prdata);
            errors++;
        end
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_word rand_word();
        t_in_word w;
        int r;
        r = $urandom_range(0, 99);
        w.command = (r < 45) ? CMD_BLOCK : (r < 80) ? CMD_QUERY : (r < 95) ? CMD_CLEANUP : CMD_NOP;
        w.address = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 15)];
        r = $urandom_range(0, 99);
        w.ttl = (r < 8) ? 20'hFFFFF : (r < 16) ? 20'd0 :
                (r < 30) ? 20'($urandom) : 20'($urandom_range(1, 40));
        now_t += $urandom_range(0, 20);
        r = $urandom_range(0, 59);
        if (r == 0) now_t = $urandom;
        else if (r == 1) now_t = 32'hFFFF_FFF0;
        w.now = now_t;
        return w;
    endfunction

    // Receiver: random stalls, mostly short with a few long ones; check in order.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_out_word ex;
        if (o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, o_out_data);
                errors++;
            end else begin
                ex = expected_words.pop_front();
                if (o_out_data.status !== ex.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, ex.status,
                             o_out_data.status);
                    errors++;
                end
                if (o_out_data.blocked !== ex.blocked) begin
                    $display("%0t: blocked expected %0d actual %0d", $time, ex.blocked,
                             o_out_data.blocked);
                    errors++;
                end
                if (o_out_data.released !== ex.released) begin
                    $display("%0t: released expected %0d actual %0d", $time, ex.released,
                             o_out_data.released);
                    errors++;
                end
                if (o_out_data.heap_fill !== ex.heap_fill) begin
                    $display("%0t: heap_fill expected %0d actual %0d", $time, ex.heap_fill,
                             o_out_data.heap_fill);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                          : $urandom_range(1, 3);
        end
    end

    typedef struct {
        t_in_word  w;
        bit        known;
        t_out_word r;
    } t_dir_row;

    initial begin
        #500_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_dir_row  dir_rows[$];
        t_out_word got;
        t_in_word  w;
        int        limits[7];
        limits = '{1, 0, 2, 16384, 32767, 7, 3};
        for (int k = 0; k < 16; k++) addr_pool[k] = $urandom;
        addr_pool[0] = 32'h0;
        addr_pool[1] = 32'hFFFF_FFFF;

        // Expected results typed in where obvious; the rest come from the model.
        dir_rows = '{
            '{'{CMD_QUERY,   32'h0,         20'h0,     32'h0},         1, '{ST_ADDED, 0, 0, 0}},
            '{'{CMD_CLEANUP, 32'h0,         20'h0,     32'hFFFF_FFFF}, 1, '{ST_ADDED, 0, 0, 0}},
            '{'{CMD_NOP,     32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF}, 1, '{ST_ADDED, 0, 0, 0}},
            '{'{CMD_BLOCK,   32'h0,         20'h0,     32'h0},         1, '{ST_ADDED, 0, 0, 1}},
            '{'{CMD_QUERY,   32'h0,         20'h0,     32'h0},         1, '{ST_ADDED, 0, 0, 1}},
            '{'{CMD_BLOCK,   32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF}, 1, '{ST_ADDED, 0, 0, 2}},
            '{'{CMD_QUERY,   32'hFFFF_FFFF, 20'h0,     32'hFFFF_FFFE}, 1, '{ST_ADDED, 1, 0, 2}},
            '{'{CMD_BLOCK,   32'hFFFF_FFFF, 20'd10,    32'd100},       1, '{ST_REFRESHED, 0, 0, 3}},
            '{'{CMD_QUERY,   32'hFFFF_FFFF, 20'h0,     32'd109},       0, '0},
            '{'{CMD_BLOCK,   32'hA5A5_5A5A, 20'd5,     32'd50},        0, '0},
            '{'{CMD_QUERY,   32'hA5A5_5A5A, 20'h0,     32'd55},        0, '0},
            '{'{CMD_CLEANUP, 32'h0,         20'h0,     32'h0},         0, '0},
            '{'{CMD_CLEANUP, 32'h0,         20'h0,     32'd200},       0, '0},
            '{'{CMD_CLEANUP, 32'h0,         20'h0,     32'hFFFF_FFFF}, 0, '0},
            '{'{CMD_BLOCK,   32'h5A5A_A5A5, 20'hFFFFF, 32'hFFF0_0000}, 0, '0},
            '{'{CMD_NOP,     32'h0,         20'h0,     32'h0},         0, '0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[j]) begin
            send_word(dir_rows[j].w);
            if (dir_rows[j].known) begin
                got = expected_words[$];
                if (got != dir_rows[j].r) begin
                    $display("%0t: directed row %0d expected %h model %h", $time, j,
                             dir_rows[j].r, got);
                    errors++;
                end
            end
        end
        drain_results();

        // Random phases, one cleanup_limit setting each, extremes included.
        foreach (limits[p]) begin
            write_limit(limits[p]);
            repeat (30) send_word(rand_word());
            drain_results();
        end

        // Clear everything, then fill the table to the top and overflow it.
        write_limit(MAX_POPS);
        w = '{CMD_CLEANUP, 32'h0, 20'h0, 32'hFFFF_FFFF};
        send_word(w);
        while (table_fill() < N_TBL) begin
            w = '{CMD_BLOCK, $urandom, 20'($urandom), now_t};
            send_word(w);
        end
        repeat (3) begin
            w = '{CMD_BLOCK, $urandom, 20'($urandom), now_t};
            send_word(w);
        end
        w = '{CMD_BLOCK, mdl_tbl_addr[N_TBL - 1], 20'd3, now_t};
        send_word(w);
        w = '{CMD_QUERY, mdl_tbl_addr[0], 20'd0, now_t};
        send_word(w);
        drain_results();
        w = '{CMD_CLEANUP, 32'h0, 20'h0, 32'hFFFF_FFFF};
        send_word(w);
        repeat (10) send_word(rand_word());

        drain_results();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ttl_abt_pkg.sv
hw/rtl/ttl_address_block_table_unit.sv
verif/tb_ttl_address_block_table_unit.sv
